[src/tqpc_pkg.sv]
package tqpc_pkg;

	// Default frame length limit in bytes
	localparam int MAX_FRAME_BYTES_DEF = 2048;

	// Frame layout
	localparam int MAC_BYTES      = 14;
	localparam int IP_LEN_HI_POS  = 16;
	localparam int IP_LEN_LO_POS  = 17;
	localparam int IP_PROTO_POS   = 23;
	localparam int IP_ADDR_FIRST  = 26;
	localparam int IP_ADDR_LAST   = 33;
	localparam int IP_DST_FIRST   = 30;
	localparam int TCP_PORT_BYTES = 4;
	localparam int TCP_OFFSET_POS = 12;
	localparam int TDS_KEEP       = 15;
	localparam int MIN_HDR_WORDS  = 5;

	// Protocol codes
	localparam logic [7:0] IP_PROTO_TCP    = 8'h06;
	localparam logic [7:0] TDS_TYPE_NORMAL = 8'h0f;
	localparam logic [7:0] TOKEN_LANGUAGE  = 8'h21;
	localparam logic [7:0] TOKEN_DBRPC     = 8'he6;
	localparam logic [7:0] RPC_NAME_MAX    = 8'h0f;

	typedef enum logic [3:0] {
		KIND_BAD_IP   = 4'd0,
		KIND_NOT_TCP  = 4'd1,
		KIND_BAD_TCP  = 4'd2,
		KIND_TRUNC    = 4'd3,
		KIND_NOT_TDS  = 4'd4,
		KIND_NOT_LAST = 4'd5,
		KIND_OTHER    = 4'd6,
		KIND_SQL      = 4'd7,
		KIND_RPC      = 4'd8
	} kind_t;

	// Header fields of one finished frame, handed to the classifier
	typedef struct packed {
		logic [7:0]                 n_bytes;   // bytes received, saturated at 255
		logic [3:0]                 ip_words;
		logic [15:0]                ip_total;
		logic [7:0]                 ip_proto;
		logic [31:0]                src_addr;
		logic [31:0]                dst_addr;
		logic [15:0]                src_port;
		logic [15:0]                dst_port;
		logic [3:0]                 tcp_words;
		logic [TDS_KEEP-1:0][7:0]   tds;
	} snap_t;

	// One frame descriptor
	typedef struct packed {
		logic [15:0] text_length;
		logic [10:0] text_offset;
		logic [15:0] dest_port;
		logic [15:0] source_port;
		logic [31:0] dest_address;
		logic [31:0] source_address;
		logic        text_shown;
		kind_t       kind;
	} result_t;

endpackage

[src/tqpc_capture.sv]
module tqpc_capture #(
	parameter int MAX_FRAME_BYTES = tqpc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	output logic            snap_valid,
	input  logic            snap_ready,
	output tqpc_pkg::snap_t snap
);
	import tqpc_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CMP_W = (POS_W > 9) ? POS_W : 9;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Working header state of the frame in progress
	logic [POS_W-1:0]         pos_q;
	logic [3:0]               ihw_q;
	logic [15:0]              total_q;
	logic [7:0]               proto_q;
	logic [31:0]              src_addr_q;
	logic [31:0]              dst_addr_q;
	logic [15:0]              src_port_q;
	logic [15:0]              dst_port_q;
	logic [3:0]               thw_q;
	logic [TDS_KEEP-1:0][7:0] tds_q;

	logic [POS_W-1:0]         pos_d;
	logic [3:0]               ihw_d;
	logic [15:0]              total_d;
	logic [7:0]               proto_d;
	logic [31:0]              src_addr_d;
	logic [31:0]              dst_addr_d;
	logic [15:0]              src_port_d;
	logic [15:0]              dst_port_d;
	logic [3:0]               thw_d;
	logic [TDS_KEEP-1:0][7:0] tds_d;

	logic             snap_valid_s2;
	snap_t            snap_s2;
	logic             snap_free;
	logic             go_s1;
	logic [CMP_W-1:0] p_c;
	logic [CMP_W-1:0] t_c;
	logic [CMP_W-1:0] s_c;
	logic [CMP_W-1:0] tds_diff;
	logic [CMP_W-1:0] n_c;
	logic [7:0]       n_sat;

	// Handshake: non-last bytes always move on, a last byte needs a free snapshot
	assign snap_free = !snap_valid_s2 || snap_ready;
	assign go_s1     = valid_s1 && (!last_s1 || snap_free);
	assign in_ready  = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Header offsets from the current state
	assign p_c      = CMP_W'(pos_q);
	assign t_c      = CMP_W'(MAC_BYTES) + CMP_W'({ihw_q, 2'b00});
	assign s_c      = t_c + CMP_W'({thw_q, 2'b00});
	assign tds_diff = p_c - s_c;

	// Capture the byte at its frame position
	always_comb begin
		pos_d      = pos_q;
		ihw_d      = ihw_q;
		total_d    = total_q;
		proto_d    = proto_q;
		src_addr_d = src_addr_q;
		dst_addr_d = dst_addr_q;
		src_port_d = src_port_q;
		dst_port_d = dst_port_q;
		thw_d      = thw_q;
		tds_d      = tds_q;
		if (pos_q < POS_W'(MAX_FRAME_BYTES)) begin
			pos_d = pos_q + POS_W'(1);
			if (p_c == CMP_W'(MAC_BYTES)) begin
				ihw_d = byte_s1[3:0];
			end else if (p_c == CMP_W'(IP_LEN_HI_POS)) begin
				total_d[15:8] = byte_s1;
			end else if (p_c == CMP_W'(IP_LEN_LO_POS)) begin
				total_d[7:0] = byte_s1;
			end else if (p_c == CMP_W'(IP_PROTO_POS)) begin
				proto_d = byte_s1;
			end else if (p_c >= CMP_W'(IP_ADDR_FIRST) && p_c <= CMP_W'(IP_ADDR_LAST)) begin
				if (p_c < CMP_W'(IP_DST_FIRST)) begin
					src_addr_d = {src_addr_q[23:0], byte_s1};
				end else begin
					dst_addr_d = {dst_addr_q[23:0], byte_s1};
				end
			end
			if (ihw_q >= 4'(MIN_HDR_WORDS)) begin
				if (p_c >= t_c && p_c < t_c + CMP_W'(TCP_PORT_BYTES)) begin
					if (p_c < t_c + CMP_W'(2)) begin
						src_port_d = {src_port_q[7:0], byte_s1};
					end else begin
						dst_port_d = {dst_port_q[7:0], byte_s1};
					end
				end else if (p_c == t_c + CMP_W'(TCP_OFFSET_POS)) begin
					thw_d = byte_s1[7:4];
				end
				if (thw_q >= 4'(MIN_HDR_WORDS) && p_c >= s_c && tds_diff < CMP_W'(TDS_KEEP)) begin
					tds_d[tds_diff[3:0]] = byte_s1;
				end
			end
		end
	end

	// Saturate the byte count: every decision threshold lies below 255
	assign n_c   = CMP_W'(pos_d);
	assign n_sat = (n_c > CMP_W'(255)) ? 8'hff : n_c[7:0];

	// Advance frame state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ihw_q      <= '0;
			total_q    <= '0;
			proto_q    <= '0;
			src_addr_q <= '0;
			dst_addr_q <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
			thw_q      <= '0;
			tds_q      <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				pos_q      <= '0;
				ihw_q      <= '0;
				total_q    <= '0;
				proto_q    <= '0;
				src_addr_q <= '0;
				dst_addr_q <= '0;
				src_port_q <= '0;
				dst_port_q <= '0;
				thw_q      <= '0;
				tds_q      <= '0;
			end else begin
				pos_q      <= pos_d;
				ihw_q      <= ihw_d;
				total_q    <= total_d;
				proto_q    <= proto_d;
				src_addr_q <= src_addr_d;
				dst_addr_q <= dst_addr_d;
				src_port_q <= src_port_d;
				dst_port_q <= dst_port_d;
				thw_q      <= thw_d;
				tds_q      <= tds_d;
			end
		end
	end

	// Snapshot of the finished frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (go_s1 && last_s1) begin
			snap_valid_s2 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			snap_s2.n_bytes   <= n_sat;
			snap_s2.ip_words  <= ihw_d;
			snap_s2.ip_total  <= total_d;
			snap_s2.ip_proto  <= proto_d;
			snap_s2.src_addr  <= src_addr_d;
			snap_s2.dst_addr  <= dst_addr_d;
			snap_s2.src_port  <= src_port_d;
			snap_s2.dst_port  <= dst_port_d;
			snap_s2.tcp_words <= thw_d;
			snap_s2.tds       <= tds_d;
		end
	end

	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

	// Checks
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_FRAME_BYTES))
		else $error("byte count beyond frame limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && last_s1 |=> pos_q == '0 && ihw_q == '0 && thw_q == '0)
		else $error("frame state not cleared after last byte");

	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid_s2 && !snap_ready |=> snap_valid_s2 && $stable(snap_s2))
		else $error("snapshot lost while stalled");

	a_last_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && snap_valid_s2 && !snap_ready |-> !go_s1)
		else $error("last byte advanced into a full snapshot");

endmodule

[src/tqpc_classify.sv]
module tqpc_classify (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              snap_valid,
	output logic              snap_ready,
	input  tqpc_pkg::snap_t   snap,
	output logic              res_valid,
	input  logic              res_ready,
	output tqpc_pkg::result_t res
);
	import tqpc_pkg::*;

	logic [8:0]         n9;
	logic [8:0]         t9;
	logic [8:0]         s9;
	logic [8:0]         sql_off;
	logic [8:0]         rpc_off;
	logic [15:0]        plen;
	logic [15:0]        sql_len;
	logic [7:0]         rpc_len;
	logic signed [17:0] size;
	logic signed [17:0] sql_need;
	logic signed [17:0] rpc_need;
	logic               match;
	logic               sql_cand;
	logic               rpc_cand;
	logic               sql_ok;
	logic               rpc_ok;
	result_t            res_d;
	result_t            res_q;
	logic               res_valid_q;

	// Header offsets and length arithmetic
	assign n9       = {1'b0, snap.n_bytes};
	assign t9       = 9'(MAC_BYTES) + {3'b000, snap.ip_words, 2'b00};
	assign s9       = t9 + {3'b000, snap.tcp_words, 2'b00};
	assign sql_off  = s9 + 9'd14;
	assign rpc_off  = s9 + 9'd12;
	assign plen     = {snap.tds[2], snap.tds[3]};
	assign sql_len  = {snap.tds[11], snap.tds[12]};
	assign rpc_len  = snap.tds[11];
	assign size     = $signed({2'b00, snap.ip_total})
	                - $signed({12'd0, snap.ip_words, 2'b00})
	                - $signed({12'd0, snap.tcp_words, 2'b00});
	assign sql_need = $signed({2'b00, sql_len}) + 18'sd13;
	assign rpc_need = $signed({10'd0, rpc_len}) + 18'sd12;
	assign match    = (size == $signed({2'b00, plen}));
	assign sql_cand = (snap.tds[8] == TOKEN_LANGUAGE) && match && (snap.tds[9] == 8'h00);
	assign rpc_cand = (snap.tds[8] == TOKEN_DBRPC) && match;
	assign sql_ok   = (snap.tds[13] <= 8'd1) && (size >= sql_need) && (sql_len != 16'd0);
	assign rpc_ok   = (rpc_len != 8'd0) && (size >= rpc_need);

	// Decide the frame kind in header order; a missing byte ends the decision
	always_comb begin
		res_d                = '0;
		res_d.kind           = KIND_OTHER;
		res_d.source_address = snap.src_addr;
		res_d.dest_address   = snap.dst_addr;
		res_d.source_port    = snap.src_port;
		res_d.dest_port      = snap.dst_port;
		if (n9 <= 9'(MAC_BYTES)) begin
			res_d.kind = KIND_TRUNC;
		end else if (snap.ip_words < 4'(MIN_HDR_WORDS)) begin
			res_d.kind = KIND_BAD_IP;
		end else if (n9 <= 9'(IP_ADDR_LAST)) begin
			res_d.kind = KIND_TRUNC;
		end else if (snap.ip_proto != IP_PROTO_TCP) begin
			res_d.kind = KIND_NOT_TCP;
		end else if (n9 <= t9 + 9'(TCP_OFFSET_POS)) begin
			res_d.kind = KIND_TRUNC;
		end else if (snap.tcp_words < 4'(MIN_HDR_WORDS)) begin
			res_d.kind = KIND_BAD_TCP;
		end else if (n9 <= s9) begin
			res_d.kind = KIND_TRUNC;
		end else if (snap.tds[0] != TDS_TYPE_NORMAL) begin
			res_d.kind = KIND_NOT_TDS;
		end else if (n9 <= s9 + 9'd1) begin
			res_d.kind = KIND_TRUNC;
		end else if (snap.tds[1] == 8'h00) begin
			res_d.kind = KIND_NOT_LAST;
		end else if (n9 <= s9 + 9'd9) begin
			res_d.kind = KIND_TRUNC;
		end else if (sql_cand) begin
			if (n9 <= s9 + 9'd13) begin
				res_d.kind = KIND_TRUNC;
			end else if (sql_ok) begin
				if (sql_len > 16'd1 && plen > sql_len && n9 <= sql_off) begin
					res_d.kind = KIND_TRUNC;
				end else begin
					res_d.kind        = KIND_SQL;
					res_d.text_shown  = (sql_len > 16'd1) && (plen > sql_len)
					                 && (snap.tds[14] != 8'h00);
					res_d.text_offset = {2'b00, sql_off};
					res_d.text_length = sql_len - 16'd1;
				end
			end
		end else if (rpc_cand) begin
			if (n9 <= s9 + 9'd10) begin
				res_d.kind = KIND_TRUNC;
			end else if (snap.tds[10] <= RPC_NAME_MAX) begin
				if (n9 <= s9 + 9'd11) begin
					res_d.kind = KIND_TRUNC;
				end else if (rpc_ok) begin
					if (rpc_len > 8'd1 && plen > {8'h00, rpc_len} && n9 <= rpc_off) begin
						res_d.kind = KIND_TRUNC;
					end else begin
						res_d.kind        = KIND_RPC;
						res_d.text_shown  = (rpc_len > 8'd1) && (plen > {8'h00, rpc_len})
						                 && (snap.tds[12] != 8'h00);
						res_d.text_offset = {2'b00, rpc_off};
						res_d.text_length = {8'h00, rpc_len};
					end
				end
			end
		end
	end

	// Result register
	assign snap_ready = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (snap_ready) begin
			res_valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks
	a_text_only_for_query: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kind != KIND_SQL && res_q.kind != KIND_RPC
		|-> !res_q.text_shown && res_q.text_offset == '0 && res_q.text_length == '0)
		else $error("text fields set on a non-query descriptor");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |=> res_valid_q && $stable(res_q))
		else $error("descriptor changed while stalled");

	a_text_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.kind == KIND_SQL || res_q.kind == KIND_RPC)
		|-> res_q.text_offset > 11'(MAC_BYTES))
		else $error("query text placed inside the MAC header");

endmodule

[src/tds_query_packet_classifier.sv]
// Channel   Dir  Payload                                             Handshake
// s_*       in   tdata: frame_byte; tlast: frame_end                 tvalid/tready
// m_*       out  tdata: kind .. text_length (128 bits)               tvalid/tready
//
// One frame byte is taken every cycle unless a last byte waits on a full snapshot.
// After the last byte of a frame is transferred, its descriptor moves
// through the snapshot (capture) and then the result register (classify);
// the input register loads on the transfer edge itself.
// arst_n clears all control and frame state at once; no clearing pass.
// A stalled output holds back only a last byte that finds the snapshot full.
module tds_query_packet_classifier #(
	parameter int MAX_FRAME_BYTES = tqpc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] frame_byte
	input  logic         s_tlast,   // frame_end
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // [3:0] kind, [4] text_shown, [36:5] source_address,
	                                // [68:37] dest_address, [84:69] source_port,
	                                // [100:85] dest_port, [111:101] text_offset,
	                                // [127:112] text_length
);
	import tqpc_pkg::*;

	logic    snap_valid;
	logic    snap_ready;
	snap_t   snap;
	result_t res;

	tqpc_capture #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	tqpc_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	// Pack the descriptor, first field lowest
	assign m_tdata = {res.text_length, res.text_offset, res.dest_port, res.source_port,
	                  res.dest_address, res.source_address, res.text_shown, res.kind};

endmodule

[verif/tds_query_packet_classifier_checker.sv]
`timescale 1ns / 1ps

module tds_query_packet_classifier_checker #(
	parameter int MAX_FRAME_BYTES = tqpc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] frame_byte
	input  logic         s_tlast,   // frame_end
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,   // [3:0] kind, [4] text_shown, [36:5] source_address,
	                                // [68:37] dest_address, [84:69] source_port,
	                                // [100:85] dest_port, [111:101] text_offset,
	                                // [127:112] text_length
	output int           mismatch_count,
	output int           outstanding
);

	import tqpc_pkg::*;

	// Header fields captured from the frame in progress
	int          byte_count;
	logic [3:0]  ihl_words;
	logic [15:0] ip_len;
	logic [7:0]  ip_proto;
	logic [31:0] addr [2];
	logic [15:0] port [2];
	logic [3:0]  doff_words;
	logic [7:0]  tds_hdr [TDS_KEEP];

	// Descriptors predicted for finished frames, oldest first
	result_t pending_descriptors [$];

	function automatic void clear_frame();
		byte_count = 0;
		ihl_words  = '0;
		ip_len     = '0;
		ip_proto   = '0;
		addr[0]    = '0;
		addr[1]    = '0;
		port[0]    = '0;
		port[1]    = '0;
		doff_words = '0;
		foreach (tds_hdr[i])
			tds_hdr[i] = '0;
	endfunction

	// Capture one byte at frame position p
	function automatic void capture_byte(int p, logic [7:0] b);
		int k;
		int t;
		int s;
		if (p == MAC_BYTES) begin
			ihl_words = b[3:0];
		end else if (p == IP_LEN_HI_POS) begin
			ip_len[15:8] = b;
		end else if (p == IP_LEN_LO_POS) begin
			ip_len[7:0] = b;
		end else if (p == IP_PROTO_POS) begin
			ip_proto = b;
		end else if (p >= IP_ADDR_FIRST && p <= IP_ADDR_LAST) begin
			k = (p - IP_ADDR_FIRST) >> 2;
			addr[k] = {addr[k][23:0], b};
		end
		if (ihl_words >= MIN_HDR_WORDS) begin
			t = MAC_BYTES + 4 * int'(ihl_words);
			if (p >= t && p < t + TCP_PORT_BYTES) begin
				k = (p - t) >> 1;
				port[k] = {port[k][7:0], b};
			end else if (p == t + TCP_OFFSET_POS) begin
				doff_words = b[7:4];
			end
			if (doff_words >= MIN_HDR_WORDS) begin
				s = t + 4 * int'(doff_words);
				if (p >= s && p < s + TDS_KEEP)
					tds_hdr[p - s] = b;
			end
		end
	endfunction

	// Classify the finished frame of n bytes; text fields stay zero unless sql or rpc
	function automatic kind_t classify_frame(int n, output bit shown, output int off,
	                                         output int len);
		int   t;
		int   s;
		int   plen;
		int   size;
		int   sl;
		int   rl;
		bit   match;
		kind_t k;
		shown = 0;
		off   = 0;
		len   = 0;
		k     = KIND_OTHER;
		if (n <= MAC_BYTES) return KIND_TRUNC;
		if (ihl_words < MIN_HDR_WORDS) return KIND_BAD_IP;
		if (n <= IP_ADDR_LAST) return KIND_TRUNC;
		if (ip_proto != IP_PROTO_TCP) return KIND_NOT_TCP;
		t = MAC_BYTES + 4 * int'(ihl_words);
		if (n <= t + TCP_OFFSET_POS) return KIND_TRUNC;
		if (doff_words < MIN_HDR_WORDS) return KIND_BAD_TCP;
		s = t + 4 * int'(doff_words);
		if (n <= s) return KIND_TRUNC;
		if (tds_hdr[0] != TDS_TYPE_NORMAL) return KIND_NOT_TDS;
		if (n <= s + 1) return KIND_TRUNC;
		if (tds_hdr[1] == 8'h00) return KIND_NOT_LAST;
		if (n <= s + 9) return KIND_TRUNC;

		// Payload size may go negative and then never matches the TDS length
		plen  = int'({tds_hdr[2], tds_hdr[3]});
		size  = int'(ip_len) - 4 * int'(ihl_words) - 4 * int'(doff_words);
		match = (plen == size);

		// Language request: text starts after the 14-byte header
		if (tds_hdr[8] == TOKEN_LANGUAGE && match && tds_hdr[9] == 8'h00) begin
			if (n <= s + 13) return KIND_TRUNC;
			sl = int'({tds_hdr[11], tds_hdr[12]});
			if (tds_hdr[13] <= 8'd1 && size >= sl + 13 && sl > 0) begin
				if (sl > 1 && plen > sl) begin
					if (n <= s + 14) return KIND_TRUNC;
					shown = (tds_hdr[14] != 8'h00);
				end
				k   = KIND_SQL;
				off = s + 14;
				len = sl - 1;
			end
		end

		// RPC call: procedure name follows its length byte
		if (tds_hdr[8] == TOKEN_DBRPC && match) begin
			if (n <= s + 10) return KIND_TRUNC;
			if (tds_hdr[10] <= RPC_NAME_MAX) begin
				if (n <= s + 11) return KIND_TRUNC;
				rl = int'(tds_hdr[11]);
				if (rl > 0 && size >= rl + 12) begin
					if (rl > 1 && plen > rl) begin
						if (n <= s + 12) return KIND_TRUNC;
						shown = (tds_hdr[12] != 8'h00);
					end
					k   = KIND_RPC;
					off = s + 12;
					len = rl;
				end
			end
		end
		return k;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin : track
		result_t want;
		result_t got;
		bit      shown;
		int      off;
		int      len;
		if (!arst_n) begin
			clear_frame();
			pending_descriptors.delete();
			mismatch_count = 0;
			outstanding    = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				// Bytes past the length limit are dropped but tlast still closes
				if (byte_count < MAX_FRAME_BYTES) begin
					capture_byte(byte_count, s_tdata);
					byte_count++;
				end
				if (s_tlast) begin
					want.kind           = classify_frame(byte_count, shown, off, len);
					want.text_shown     = shown;
					want.source_address = addr[0];
					want.dest_address   = addr[1];
					want.source_port    = port[0];
					want.dest_port      = port[1];
					want.text_offset    = off[10:0];
					want.text_length    = len[15:0];
					pending_descriptors.push_back(want);
					clear_frame();
				end
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_descriptors.size() == 0) begin
					$error("descriptor with no frame waiting: 0x%0h", m_tdata);
					mismatch_count++;
				end else begin
					want = pending_descriptors.pop_front();
					check_field("kind", 32'(want.kind), 32'(got.kind));
					check_field("text_shown", 32'(want.text_shown), 32'(got.text_shown));
					check_field("source_address", want.source_address, got.source_address);
					check_field("dest_address", want.dest_address, got.dest_address);
					check_field("source_port", 32'(want.source_port), 32'(got.source_port));
					check_field("dest_port", 32'(want.dest_port), 32'(got.dest_port));
					check_field("text_offset", 32'(want.text_offset), 32'(got.text_offset));
					check_field("text_length", 32'(want.text_length), 32'(got.text_length));
				end
			end
			outstanding = pending_descriptors.size();
		end
	end

endmodule

[verif/tds_query_packet_classifier_tb.sv]
`timescale 1ns / 1ps

module tds_query_packet_classifier_tb;

	import tqpc_pkg::*;

	localparam int         STALL_LIMIT    = 4000;
	localparam int         HOLD_CYCLES    = 400;
	localparam int         FRAME_LIMIT    = 192;
	localparam int         TEXT_CARRY     = 16;
	localparam logic [7:0] IP_PROTO_UDP   = 8'h11;
	localparam logic [7:0] TDS_TYPE_OTHER = 8'h10;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // [7:0] frame_byte
	logic         s_tlast;   // frame_end
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // [3:0] kind, [4] text_shown, [36:5] source_address,
	                         // [68:37] dest_address, [84:69] source_port,
	                         // [100:85] dest_port, [111:101] text_offset,
	                         // [127:112] text_length

	int mismatch_count;
	int outstanding;
	int tx_idle_pct;
	int rx_idle_pct;
	int bytes_sent;
	int frames_sent;
	int stall_cycles;
	bit hold_req;

	// Frame under construction and where its TCP and TDS headers start
	logic [7:0] frame_bytes [$];
	int         tcp_at;
	int         tds_at;

	tds_query_packet_classifier #(
		.MAX_FRAME_BYTES(FRAME_LIMIT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	tds_query_packet_classifier_checker #(
		.MAX_FRAME_BYTES(FRAME_LIMIT)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random backpressure, or a long hold-off when requested
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one byte, idling at random first, and hold it until the transfer
	task automatic send_frame_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_frame_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		frames_sent++;
	endtask

	// Pause the sender until every descriptor has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cut_frame(int n);
		while (frame_bytes.size() > n)
			void'(frame_bytes.pop_back());
	endtask

	// Build a consistent sql or rpc frame; declared lengths follow tlen,
	// but at most TEXT_CARRY text bytes are actually carried
	task automatic build_query_frame(int ihl, int doff, bit rpc, int tlen);
		int          payload;
		int          n_text;
		logic [15:0] total;
		frame_bytes.delete();
		tcp_at  = MAC_BYTES + 4 * ihl;
		tds_at  = tcp_at + 4 * doff;
		payload = (rpc ? 12 : 13) + tlen + int'($urandom_range(3));
		total   = 16'(4 * ihl + 4 * doff + payload);
		while (frame_bytes.size() < tds_at)
			frame_bytes.push_back(8'($urandom_range(255)));
		frame_bytes[MAC_BYTES]     = {4'h4, ihl[3:0]};
		frame_bytes[IP_LEN_HI_POS] = total[15:8];
		frame_bytes[IP_LEN_LO_POS] = total[7:0];
		frame_bytes[IP_PROTO_POS]  = IP_PROTO_TCP;
		frame_bytes[tcp_at + TCP_OFFSET_POS] = {doff[3:0], 4'($urandom_range(15))};

		// TDS header: type, last flag, length, then token fields
		frame_bytes.push_back(TDS_TYPE_NORMAL);
		frame_bytes.push_back(8'($urandom_range(255, 1)));
		frame_bytes.push_back(payload[15:8]);
		frame_bytes.push_back(payload[7:0]);
		repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
		if (rpc) begin
			frame_bytes.push_back(TOKEN_DBRPC);
			frame_bytes.push_back(8'($urandom_range(255)));
			frame_bytes.push_back(8'($urandom_range(RPC_NAME_MAX)));
			frame_bytes.push_back(tlen[7:0]);
			n_text = payload - 12;
		end else begin
			frame_bytes.push_back(TOKEN_LANGUAGE);
			frame_bytes.push_back(8'h00);
			frame_bytes.push_back(8'($urandom_range(255)));
			frame_bytes.push_back(tlen[15:8]);
			frame_bytes.push_back(tlen[7:0]);
			frame_bytes.push_back(8'($urandom_range(1)));
			n_text = payload - 14;
		end
		if (n_text > TEXT_CARRY)
			n_text = TEXT_CARRY;
		if (n_text > 0)
			frame_bytes.push_back(8'($urandom_range(255, 1)));
		for (int i = 1; i < n_text; i++)
			frame_bytes.push_back(8'($urandom_range(255)));

		// Ethernet padding past the IP datagram
		repeat ($urandom_range(3)) frame_bytes.push_back(8'($urandom_range(255)));
	endtask

	task automatic run_directed();
		build_query_frame(5, 5, 0, 12);
		send_frame();
		build_query_frame(5, 5, 1, 9);
		send_frame();
		build_query_frame(15, 15, 0, 20);
		frame_bytes[tds_at + 14] = 8'hff;
		send_frame();
		build_query_frame(15, 15, 1, 255);
		send_frame();
		// single byte, and a frame that ends inside the MAC header
		frame_bytes.delete();
		frame_bytes.push_back(8'hff);
		send_frame();
		build_query_frame(5, 5, 0, 4);
		cut_frame(MAC_BYTES);
		send_frame();
		// header rejections
		build_query_frame(5, 5, 0, 6);
		frame_bytes[MAC_BYTES] = 8'h44;
		send_frame();
		build_query_frame(5, 5, 0, 6);
		frame_bytes[IP_PROTO_POS] = IP_PROTO_UDP;
		send_frame();
		build_query_frame(5, 5, 1, 6);
		frame_bytes[tcp_at + TCP_OFFSET_POS] = 8'h40;
		send_frame();
		build_query_frame(5, 5, 1, 6);
		frame_bytes[tds_at] = TDS_TYPE_OTHER;
		send_frame();
		build_query_frame(5, 5, 0, 6);
		frame_bytes[tds_at + 1] = 8'h00;
		send_frame();
		// one-byte sql text, blank first text byte, empty sql
		build_query_frame(5, 5, 0, 1);
		send_frame();
		build_query_frame(5, 5, 0, 8);
		frame_bytes[tds_at + 14] = 8'h00;
		send_frame();
		build_query_frame(5, 5, 0, 0);
		send_frame();
		// rpc with an option byte above the limit, then a length mismatch
		build_query_frame(5, 5, 1, 7);
		frame_bytes[tds_at + 10] = RPC_NAME_MAX + 8'd1;
		send_frame();
		build_query_frame(5, 5, 0, 7);
		frame_bytes[tds_at + 3] = frame_bytes[tds_at + 3] ^ 8'h01;
		send_frame();
		// language id out of range, and a cut inside the TDS header
		build_query_frame(5, 5, 0, 7);
		frame_bytes[tds_at + 13] = 8'd2;
		send_frame();
		build_query_frame(6, 7, 1, 7);
		cut_frame(tds_at + 5);
		send_frame();
		// declared sql text far longer than the frame
		build_query_frame(5, 5, 0, 60000);
		send_frame();
		// overlong frame: bytes past the limit are not counted
		build_query_frame(5, 5, 0, 10);
		while (frame_bytes.size() < FRAME_LIMIT + 8)
			frame_bytes.push_back(8'($urandom_range(255)));
		send_frame();
	endtask

	// Mostly well-formed queries with random content, some spoiled or cut
	task automatic send_random_frame();
		int r;
		int ihl;
		int doff;
		int tlen;
		int pos;
		bit rpc;
		r = $urandom_range(99);
		if (r < 10) begin
			frame_bytes.delete();
			repeat ($urandom_range(60, 1)) frame_bytes.push_back(8'($urandom_range(255)));
			send_frame();
			return;
		end
		ihl  = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
		doff = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
		rpc  = 1'($urandom_range(1));
		r    = $urandom_range(99);
		if (r < 10)
			tlen = rpc ? $urandom_range(255) : $urandom_range(65535);
		else if (r < 20)
			tlen = $urandom_range(1);
		else
			tlen = $urandom_range(30, 2);
		build_query_frame(ihl, doff, rpc, tlen);

		r = $urandom_range(99);
		if (r < 15) begin
			cut_frame($urandom_range(frame_bytes.size(), 1));
		end else if (r < 40) begin
			case ($urandom_range(7))
				0:       pos = MAC_BYTES;
				1:       pos = IP_LEN_HI_POS + $urandom_range(1);
				2:       pos = IP_PROTO_POS;
				3:       pos = tcp_at + TCP_OFFSET_POS;
				default: pos = tds_at + $urandom_range(TDS_KEEP - 1);
			endcase
			if (pos < frame_bytes.size()) begin
				case ($urandom_range(2))
					0:       frame_bytes[pos] = 8'h00;
					1:       frame_bytes[pos] = 8'hff;
					default: frame_bytes[pos] = 8'($urandom_range(255));
				endcase
			end
		end
		send_frame();
	endtask

	initial begin
		int start_bytes;
		int start_frames;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		hold_req     = 1'b0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		bytes_sent   = 0;
		frames_sent  = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin tx_idle_pct = 18; rx_idle_pct = 45; end
				1:       begin tx_idle_pct = 45; rx_idle_pct = 18; end
				default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
			endcase
			if (phase == 0) begin
				run_directed();
			end else begin
				start_bytes  = bytes_sent;
				start_frames = frames_sent;
				while (bytes_sent - start_bytes < 150 || frames_sent - start_frames < 2)
					send_random_frame();
			end
			if (phase == 2) begin
				// stall the receiver while short frames keep coming
				hold_req = 1'b1;
				repeat (40) begin
					frame_bytes.delete();
					repeat ($urandom_range(3, 1))
						frame_bytes.push_back(8'($urandom_range(255)));
					send_frame();
				end
			end
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
